// ===== hdl/lfulru_pkg.sv =====
// Shared types and constants for the LFU replacement unit with LRU tie-break.
// No dependencies.
package lfulru_pkg;

  localparam int DefNumSets  = 64;
  localparam int DefNumWays  = 8;
  localparam int DefCountBits = 16;

  localparam int OpcodeW  = 2;
  localparam int SetIdxW  = 6;
  localparam int WayIdxW  = 3;
  localparam int TickW    = 32;

  localparam logic [TickW-1:0] TickInvalid = '1;

  typedef enum logic [OpcodeW-1:0] {
    OP_INVAL = 2'd0,
    OP_TOUCH = 2'd1,
    OP_FILL  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

endpackage

// ===== hdl/lfu_lru_tiebreak_replacement.sv =====
// LFU replacement unit with LRU tie-break: metadata memories, update and victim scan.
// Depends on lfulru_pkg.
//
// Usage
//   Command channel: a word (opcode, set, way, tick) is taken at the rising edge where
//   start_i is high and busy_o is low. Each word yields exactly one result word, shown
//   for one cycle with valid_o high. The receiver cannot stall; it must take it.
//   Opcodes: invalidate, touch (saturating count, stamp tick), fill (count 1, stamp
//   tick), victim query (smallest count, then oldest tick, then lowest way).
// Sequencing
//   Per set, one row of each memory holds all ways; the single read port is read at
//   accept and its registered data feeds the modify or the scan.
//   Invalidate/touch/fill: the row is modified and written back in ST_EXEC; the result
//   is registered from there. Victim query: one way compared per cycle by the scan unit
//   in ST_SCAN, and the result is registered after the last way. A query on a set
//   beyond NUM_SETS answers way 0 from ST_EXEC.
//   A write-back always lands before the next accept (busy interlock), so no
//   forwarding path exists.
// Reset
//   After rst_ni releases, a clearing pass writes every row to the invalidated state
//   (count 0, tick all ones), one row per cycle, with busy_o high until the last row.
module lfu_lru_tiebreak_replacement #(
  parameter int NUM_SETS   = lfulru_pkg::DefNumSets,
  parameter int NUM_WAYS   = lfulru_pkg::DefNumWays,
  parameter int COUNT_BITS = lfulru_pkg::DefCountBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lfulru_pkg::OpcodeW-1:0]  opcode_i,
  input  logic [lfulru_pkg::SetIdxW-1:0]  set_index_i,
  input  logic [lfulru_pkg::WayIdxW-1:0]  way_i,
  input  logic [lfulru_pkg::TickW-1:0]    now_tick_i,
  output logic                            valid_o,
  output logic [lfulru_pkg::WayIdxW-1:0]  victim_way_o,
  output logic                            is_victim_reply_o
);
  import lfulru_pkg::*;

  localparam int SetAw = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WayAw = $clog2(NUM_WAYS);
  localparam logic [SetAw-1:0] SetLast = SetAw'(NUM_SETS - 1);
  localparam logic [WayAw-1:0] WayLast = WayAw'(NUM_WAYS - 1);

  typedef logic [NUM_WAYS-1:0][COUNT_BITS-1:0] cnt_row_t;
  typedef logic [NUM_WAYS-1:0][TickW-1:0]      tick_row_t;

  // metadata memories, one row per set
  cnt_row_t  cnt_mem  [NUM_SETS];
  tick_row_t tick_mem [NUM_SETS];

  state_e state_q, state_d;

  logic [SetAw-1:0] clr_q, clr_d;
  logic [WayAw-1:0] scan_q, scan_d;
  logic [WayAw-1:0] best_q, best_d;

  op_e              op_q;
  logic [SetAw-1:0] addr_q;
  logic [WayAw-1:0] way_q;
  logic [TickW-1:0] tick_q;
  logic             set_ok_q;
  logic             way_ok_q;

  cnt_row_t  cnt_rd_q;
  tick_row_t tick_rd_q;

  logic accept;
  logic set_ok, way_ok;
  logic rd_en;
  logic [SetAw-1:0] in_addr;

  logic             wr_en;
  logic [SetAw-1:0] wr_addr;
  cnt_row_t         cnt_wr;
  tick_row_t        tick_wr;

  logic             take;
  logic             valid_q, valid_d;
  logic [WayIdxW-1:0] victim_q, victim_d;
  logic             isq_q, isq_d;

  assign accept  = start_i && !busy_o;
  assign set_ok  = 32'(set_index_i) < NUM_SETS;
  assign way_ok  = 32'(way_i) < NUM_WAYS;
  assign in_addr = SetAw'({{SetAw{1'b0}}, set_index_i});
  assign rd_en   = accept && set_ok;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SetLast) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_EXEC;
      ST_EXEC:  if (op_q == OP_QUERY && set_ok_q) state_d = ST_SCAN;
                else state_d = ST_IDLE;
      ST_SCAN:  if (scan_q == WayLast) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  // victim compare: smaller count, or equal count and older stamp
  assign take = (cnt_rd_q[scan_q] < cnt_rd_q[best_q]) ||
                ((cnt_rd_q[scan_q] == cnt_rd_q[best_q]) &&
                 (tick_rd_q[scan_q] < tick_rd_q[best_q]));

  always_comb begin
    clr_d    = clr_q;
    scan_d   = scan_q;
    best_d   = best_q;
    wr_en    = 1'b0;
    wr_addr  = addr_q;
    cnt_wr   = cnt_rd_q;
    tick_wr  = tick_rd_q;
    valid_d  = 1'b0;
    victim_d = victim_q;
    isq_d    = isq_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        cnt_wr  = '0;
        tick_wr = '1;
        clr_d   = clr_q + SetAw'(1);
      end
      ST_IDLE: begin
        scan_d = WayAw'(1);
        best_d = '0;
      end
      ST_EXEC: begin
        if (op_q != OP_QUERY) begin
          wr_en = set_ok_q && way_ok_q;
          case (op_q)
            OP_INVAL: begin
              cnt_wr[way_q]  = '0;
              tick_wr[way_q] = TickInvalid;
            end
            OP_TOUCH: begin
              if (cnt_rd_q[way_q] != '1) cnt_wr[way_q] = cnt_rd_q[way_q] + COUNT_BITS'(1);
              tick_wr[way_q] = tick_q;
            end
            default: begin
              cnt_wr[way_q]  = COUNT_BITS'(1);
              tick_wr[way_q] = tick_q;
            end
          endcase
        end
        if (!(op_q == OP_QUERY && set_ok_q)) begin
          valid_d  = 1'b1;
          victim_d = '0;
          isq_d    = (op_q == OP_QUERY);
        end
      end
      ST_SCAN: begin
        if (take) best_d = scan_q;
        scan_d = scan_q + WayAw'(1);
        if (scan_q == WayLast) begin
          valid_d  = 1'b1;
          victim_d = WayIdxW'({{WayIdxW{1'b0}}, best_d});
          isq_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      scan_q  <= '0;
      best_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      best_q  <= best_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
    isq_q    <= isq_d;
    if (accept) begin
      op_q     <= op_e'(opcode_i);
      addr_q   <= in_addr;
      way_q    <= WayAw'({{WayAw{1'b0}}, way_i});
      tick_q   <= now_tick_i;
      set_ok_q <= set_ok;
      way_ok_q <= way_ok;
    end
  end

  // memories: one read port, one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cnt_rd_q  <= cnt_mem[in_addr];
      tick_rd_q <= tick_mem[in_addr];
    end
    if (wr_en) begin
      cnt_mem[wr_addr]  <= cnt_wr;
      tick_mem[wr_addr] <= tick_wr;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign valid_o           = valid_q;
  assign victim_way_o      = victim_q;
  assign is_victim_reply_o = isq_q;

  // ---------------- assertions ----------------
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_SCAN))
    else $error("result strobe without a finishing operation");

  a_nonquery_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !is_victim_reply_o) |-> (victim_way_o == '0))
    else $error("non-query result carries a victim way");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q <= WayLast && best_q < scan_q))
    else $error("victim scan index out of range");

  a_no_write_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en)
    else $error("memory write while idle");

endmodule

// ===== verif/lfu_lru_tiebreak_replacement_test.sv =====
// Testbench for lfu_lru_tiebreak_replacement: directed and random command words checked
// against a per-way count/timestamp model kept in a small scoreboard class.
// Depends on lfulru_pkg and the lfu_lru_tiebreak_replacement RTL.
module lfu_lru_tiebreak_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfulru_pkg::*;

  localparam int NumSets   = DefNumSets;
  localparam int NumWays   = DefNumWays;
  localparam int CountBits = DefCountBits;
  // The longest command is a victim scan.
  localparam int ScanLatency = NumWays + 1;

  // One expected result word.
  typedef struct packed {
    logic [WayIdxW-1:0] way;
    logic               query;
  } reply_t;

  // Scoreboard: mirrors the replacement metadata and queues the reply each command
  // word should produce, in accept order.
  class victim_tracker;
    logic [CountBits-1:0] hits  [NumSets][NumWays];
    logic [TickW-1:0]     stamp [NumSets][NumWays];
    reply_t               pending [$];
    int unsigned          errors;

    function new();
      foreach (hits[s, w]) begin
        hits[s][w]  = '0;
        stamp[s][w] = TickInvalid;
      end
      errors = 0;
    endfunction

    // Smallest count, then oldest stamp, then lowest way.
    function automatic int unsigned choose_victim(int unsigned s);
      int unsigned best;
      best = 0;
      for (int unsigned w = 1; w < NumWays; w++) begin
        if (hits[s][w] < hits[s][best] ||
            (hits[s][w] == hits[s][best] && stamp[s][w] < stamp[s][best])) begin
          best = w;
        end
      end
      return best;
    endfunction

    function void note_access(op_e op, int unsigned s, int unsigned w, logic [TickW-1:0] t);
      reply_t r;
      r = '0;
      if (op == OP_QUERY) begin
        r.query = 1'b1;
        if (s < NumSets) r.way = WayIdxW'(choose_victim(s));
      end else if (s < NumSets && w < NumWays) begin
        case (op)
          OP_INVAL: begin
            hits[s][w]  = '0;
            stamp[s][w] = TickInvalid;
          end
          OP_TOUCH: begin
            if (hits[s][w] != '1) hits[s][w] = hits[s][w] + 1'b1;
            stamp[s][w] = t;
          end
          default: begin
            hits[s][w]  = CountBits'(1);
            stamp[s][w] = t;
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_reply(logic [WayIdxW-1:0] way, logic query);
      reply_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word: victim_way %0d is_victim_reply %0b",
                 $time, way, query);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (way !== exp_r.way) begin
        $display("%0t: victim_way mismatch: expected %0d actual %0d", $time, exp_r.way, way);
        errors++;
      end
      if (query !== exp_r.query) begin
        $display("%0t: is_victim_reply mismatch: expected %0b actual %0b",
                 $time, exp_r.query, query);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [OpcodeW-1:0] opcode_i = '0;
  logic [SetIdxW-1:0] set_index_i = '0;
  logic [WayIdxW-1:0] way_i = '0;
  logic [TickW-1:0]   now_tick_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic [WayIdxW-1:0] victim_way_o;
  logic               is_victim_reply_o;

  victim_tracker book;

  // Running time base for the random part; half of the ticks move forward from here.
  logic [TickW-1:0] tick_now  = 32'd1000;
  logic [TickW-1:0] tick_last = '0;

  lfu_lru_tiebreak_replacement #(
    .NUM_SETS  (NumSets),
    .NUM_WAYS  (NumWays),
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .set_index_i      (set_index_i),
    .way_i            (way_i),
    .now_tick_i       (now_tick_i),
    .valid_o          (valid_o),
    .victim_way_o     (victim_way_o),
    .is_victim_reply_o(is_victim_reply_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled at the rising edge, before the design's updates land.
  // A word taken at this edge is booked before a result at the same edge is checked; the
  // result always belongs to an older word, which sits ahead of it in the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        book.note_access(op_e'(opcode_i), set_index_i, way_i, now_tick_i);
      end
      if (valid_o) book.check_reply(victim_way_o, is_victim_reply_o);
    end
  end

  // Present one command word and hold it until the design takes it. Called right after
  // a rising edge; start_i stays high if the next call follows at once.
  task automatic issue(op_e op, int unsigned s, int unsigned w, logic [TickW-1:0] t);
    start_i     <= 1'b1;
    opcode_i    <= op;
    set_index_i <= SetIdxW'(s);
    way_i       <= WayIdxW'(w);
    now_tick_i  <= t;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait for every booked reply, with a cap so a lost result
  // shows up as a leftover instead of a hang. The first edge lets the monitor book
  // the word taken at the edge this task was called on.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Tick mix: the range ends, repeats of the previous tick for exact ties, full-range
  // values, and in half of the picks a slowly advancing time base.
  function automatic logic [TickW-1:0] pick_tick();
    logic [TickW-1:0] t;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = 32'hFFFF_FFFE;
      2, 3: t = tick_last;
      4: t = $urandom();
      default: begin
        tick_now = tick_now + $urandom_range(0, 3);
        t = tick_now;
      end
    endcase
    if (t == TickInvalid) t = 32'hFFFF_FFFE;
    tick_last = t;
    return t;
  endfunction

  // Random traffic leans on four hot sets so that counts and stamps build up and the
  // queries see real contention; the rest spreads over every set.
  function automatic int unsigned pick_set();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 21;
        2: return 42;
        default: return 63;
      endcase
    end
    return $urandom_range(0, NumSets - 1);
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned r;
    op_e         op;

    book = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: queries on untouched sets (all ways tie at count 0, stamp all ones),
    // then a set built up by hand to hit each ordering rule and the field extremes.
    issue(OP_QUERY, 0, 0, '0);
    issue(OP_QUERY, 63, 7, 32'hFFFF_FFFE);
    for (int unsigned w = 0; w < NumWays; w++) issue(OP_FILL, 5, w, 32'd200 - w);
    issue(OP_QUERY, 5, 0, '0);                  // equal counts: oldest stamp, way 7
    issue(OP_TOUCH, 5, 7, 32'hFFFF_FFFE);
    issue(OP_QUERY, 5, 7, '0);                  // way 7 now count 2, way 6 oldest
    issue(OP_FILL, 5, 6, 32'd194);              // refill way 6 at stamp 194
    issue(OP_FILL, 5, 2, 32'd194);
    issue(OP_QUERY, 5, 3, '0);                  // exact tie between ways 2 and 6
    issue(OP_INVAL, 5, 4, '0);
    issue(OP_QUERY, 5, 4, '0);                  // invalidated way: count 0 wins
    issue(OP_TOUCH, 5, 4, '0);                  // touch on an invalid way, tick zero
    issue(OP_QUERY, 5, 0, '0);
    issue(OP_INVAL, 63, 7, 32'hFFFF_FFFE);
    issue(OP_TOUCH, 63, 7, 32'h0000_0001);
    issue(OP_QUERY, 63, 0, '0);
    drain();

    // Count growth on set 1: way 0 is touched repeatedly so its count climbs well above
    // the filled ways; the oldest filled way must win the queries.
    for (int unsigned w = 1; w < NumWays; w++) issue(OP_FILL, 1, w, 32'd100 + w);
    for (int unsigned n = 0; n < 24; n++) issue(OP_TOUCH, 1, 0, 32'd500 + n);
    issue(OP_QUERY, 1, 0, '0);
    issue(OP_TOUCH, 1, 0, 32'd7);
    issue(OP_TOUCH, 1, 0, 32'h8000_0000);
    issue(OP_QUERY, 1, 0, '0);
    drain();

    // Random part: bursts of words with random gaps, one stretch without gaps, and a
    // full drain midway.
    burst_left = 0;
    for (int unsigned i = 0; i < 1800; i++) begin
      if (i == 900) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (i < 500 || i > 800) begin
          r = $urandom_range(0, 6);
          if (r != 0) idle(r);
        end
      end
      burst_left--;
      r = $urandom_range(0, 99);
      if (r < 15) op = OP_INVAL;
      else if (r < 50) op = OP_TOUCH;
      else if (r < 68) op = OP_FILL;
      else op = OP_QUERY;
      issue(op, pick_set(), $urandom_range(0, NumWays - 1), pick_tick());
    end

    drain();
    repeat (ScanLatency + 4) @(posedge clk_i);
    if (book.pending.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, book.pending.size());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a run that hangs ends as failed.
  initial begin
    #300_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== lfu_lru_tiebreak_replacement.f =====
hdl/lfulru_pkg.sv
hdl/lfu_lru_tiebreak_replacement.sv
verif/lfu_lru_tiebreak_replacement_test.sv
